### hdl/voxel_six_neighbor_lookup_defines.svh
// Assertion macros shared by the voxel neighbor lookup block.
// Depends on nothing; included by the top level.
`ifndef VOXEL_SIX_NEIGHBOR_LOOKUP_DEFINES_SVH
`define VOXEL_SIX_NEIGHBOR_LOOKUP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define VSNL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition must never hold.
`define VSNL_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

### hdl/vsnl_pkg.sv
// Shared types, codes and default sizes for the voxel neighbor lookup block.
// Depends on nothing; used by vsnl_if, vsnl_front, vsnl_queue, vsnl_back, the top and the bench by scoped names.
package vsnl_pkg;

   // default sizes
   localparam int COORD_BITS_DEFAULT = 6;
   localparam int MAX_VOXELS_DEFAULT = 65535;
   localparam int QUEUE_DEPTH = 2;

   // fixed field widths
   localparam int FIELD_BITS = 6;
   localparam int INDEX_BITS = 16;
   localparam int DIR_BITS   = 3;
   localparam int NUM_DIRS   = 6;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // neighbor direction codes, probe order
   localparam logic [DIR_BITS-1:0] DIR_NEG_X = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_POS_X = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_NEG_Y = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_POS_Y = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_NEG_Z = 3'd4;
   localparam logic [DIR_BITS-1:0] DIR_POS_Z = 3'd5;
   localparam logic [DIR_BITS-1:0] DIR_DONE  = 3'd6;

   // classified command handed from front to back
   typedef struct packed {
      logic                  func;
      logic [FIELD_BITS-1:0] coord_x;
      logic [FIELD_BITS-1:0] coord_y;
      logic [FIELD_BITS-1:0] coord_z;
      logic [NUM_DIRS-1:0]   in_grid;
   } cmd_type;

   // status from back to front
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

### hdl/vsnl_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on vsnl_pkg for field widths.
interface vsnl_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [vsnl_pkg::FIELD_BITS-1:0] coord_x;
   logic [vsnl_pkg::FIELD_BITS-1:0] coord_y;
   logic [vsnl_pkg::FIELD_BITS-1:0] coord_z;

   modport source (output valid, func, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, func, coord_x, coord_y, coord_z, output ready);
endinterface

interface vsnl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [vsnl_pkg::INDEX_BITS-1:0] voxel_index;
   logic [vsnl_pkg::DIR_BITS-1:0]   direction;
   logic                            found;
   logic                            capacity_error;
   logic                            last;

   modport source (output valid, voxel_index, direction, found, capacity_error, last,
                   input ready);
   modport sink   (input valid, voxel_index, direction, found, capacity_error, last,
                   output ready);
endinterface

### hdl/vsnl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module vsnl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/vsnl_front.sv
// Front section: accepts request transactions, reduces coordinates and
// works out which neighbors lie inside the grid. Depends on vsnl_pkg, vsnl_if.
module vsnl_front #(
   parameter int COORD_BITS = vsnl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                      reset,
   vsnl_req_if.sink                  req_chan,
   input  vsnl_pkg::back_status_type status,
   input  logic                      queue_full,
   output logic                      push,
   output vsnl_pkg::cmd_type         push_cmd
);

   localparam int FB = vsnl_pkg::FIELD_BITS;
   // mask that keeps the low COORD_BITS bits of an input field
   localparam logic [FB-1:0] FieldMask =
      (COORD_BITS >= FB) ? {FB{1'b1}} : FB'((1 << COORD_BITS) - 1);
   localparam logic [COORD_BITS-1:0] AxisMax = {COORD_BITS{1'b1}};

   logic [FB-1:0]         red_x, red_y, red_z;
   logic [COORD_BITS-1:0] ax_x, ax_y, ax_z;

   // coordinate reduction
   assign red_x = req_chan.coord_x & FieldMask;
   assign red_y = req_chan.coord_y & FieldMask;
   assign red_z = req_chan.coord_z & FieldMask;
   assign ax_x  = COORD_BITS'(red_x);
   assign ax_y  = COORD_BITS'(red_y);
   assign ax_z  = COORD_BITS'(red_z);

   // handshake: no transactions while the grid is being cleared
   assign req_chan.ready = !reset && !status.clearing && !queue_full;
   assign push           = req_chan.valid && req_chan.ready;

   // classified command
   always_comb begin
      push_cmd.func    = req_chan.func;
      push_cmd.coord_x = red_x;
      push_cmd.coord_y = red_y;
      push_cmd.coord_z = red_z;
      push_cmd.in_grid[vsnl_pkg::DIR_NEG_X] = (ax_x != '0);
      push_cmd.in_grid[vsnl_pkg::DIR_POS_X] = (ax_x != AxisMax);
      push_cmd.in_grid[vsnl_pkg::DIR_NEG_Y] = (ax_y != '0);
      push_cmd.in_grid[vsnl_pkg::DIR_POS_Y] = (ax_y != AxisMax);
      push_cmd.in_grid[vsnl_pkg::DIR_NEG_Z] = (ax_z != '0);
      push_cmd.in_grid[vsnl_pkg::DIR_POS_Z] = (ax_z != AxisMax);
   end

endmodule

### hdl/vsnl_queue.sv
// Short command queue between front and back sections.
// Depends on vsnl_pkg.
module vsnl_queue #(
   parameter int DEPTH = vsnl_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vsnl_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output vsnl_pkg::cmd_type head_cmd
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
   localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

   vsnl_pkg::cmd_type  slot_ff [DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == FullCnt);
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntBits'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/vsnl_back.sv
// Back section: owns the occupancy grid RAM, clears it after reset, executes
// inserts and neighbor probes, and drives the response register.
// Depends on vsnl_pkg, vsnl_if, vsnl_ram.
module vsnl_back #(
   parameter int COORD_BITS = vsnl_pkg::COORD_BITS_DEFAULT,
   parameter int MAX_VOXELS = vsnl_pkg::MAX_VOXELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  vsnl_pkg::cmd_type         head_cmd,
   output logic                      pop,
   output vsnl_pkg::back_status_type status,
   vsnl_rsp_if.source                rsp_chan
);

   localparam int GridBits  = 3 * COORD_BITS;
   localparam int GridDepth = 1 << GridBits;
   localparam int IB        = vsnl_pkg::INDEX_BITS;
   localparam int DB        = vsnl_pkg::DIR_BITS;
   localparam logic [IB-1:0] MaxCount = IB'(MAX_VOXELS);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_QUERY  = 4'b0100,
      ST_FINISH = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [GridBits-1:0] clr_ff, clr_in;
   logic [IB-1:0]     count_ff, count_in;
   vsnl_pkg::cmd_type cmd_ff, cmd_in;
   logic [DB-1:0]     dir_ff, dir_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [DB-1:0]     chk_dir_ff, chk_dir_in;
   logic              chk_inside_ff, chk_inside_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IB-1:0]     pend_idx_ff, pend_idx_in;
   logic [DB-1:0]     pend_dir_ff, pend_dir_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IB-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [DB-1:0]     rsp_dir_ff, rsp_dir_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_cap_ff, rsp_cap_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM port signals
   logic                ram_wr_en, ram_rd_en;
   logic [GridBits-1:0] ram_wr_addr, ram_rd_addr;
   logic [IB-1:0]       ram_wr_data, ram_rd_data;

   logic                  can_push, hit, stall, issuing;
   logic                  push_en, push_found, push_cap, push_last;
   logic [IB-1:0]         push_idx;
   logic [DB-1:0]         push_dir;
   logic [COORD_BITS-1:0] cx, cy, cz, nx, ny, nz;

   vsnl_ram #(
      .WIDTH (IB),
      .DEPTH (GridDepth)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status.clearing = (state_ff == ST_CLEAR);
   assign can_push        = !rsp_valid_ff || rsp_chan.ready;

   // neighbor address for the direction being issued
   assign cx = COORD_BITS'(cmd_ff.coord_x);
   assign cy = COORD_BITS'(cmd_ff.coord_y);
   assign cz = COORD_BITS'(cmd_ff.coord_z);

   always_comb begin
      nx = cx;
      ny = cy;
      nz = cz;
      case (dir_ff)
         vsnl_pkg::DIR_NEG_X: nx = cx - COORD_BITS'(1);
         vsnl_pkg::DIR_POS_X: nx = cx + COORD_BITS'(1);
         vsnl_pkg::DIR_NEG_Y: ny = cy - COORD_BITS'(1);
         vsnl_pkg::DIR_POS_Y: ny = cy + COORD_BITS'(1);
         vsnl_pkg::DIR_NEG_Z: nz = cz - COORD_BITS'(1);
         vsnl_pkg::DIR_POS_Z: nz = cz + COORD_BITS'(1);
         default: begin
            nx = cx;
         end
      endcase
   end

   assign ram_rd_addr = {nz, ny, nx};

   // probe result checks; a hit waits in the pending register until the
   // next hit or the end of the probes decides whether it is the last one
   assign hit     = chk_valid_ff && chk_inside_ff && (ram_rd_data != '0);
   assign stall   = hit && pend_valid_ff && !can_push;
   assign issuing = (dir_ff != vsnl_pkg::DIR_DONE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      dir_in        = dir_ff;
      chk_valid_in  = chk_valid_ff;
      chk_dir_in    = chk_dir_ff;
      chk_inside_in = chk_inside_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_dir_in   = pend_dir_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      push_en       = 1'b0;
      push_idx      = '0;
      push_dir      = vsnl_pkg::DIR_NEG_X;
      push_found    = 1'b0;
      push_cap      = 1'b0;
      push_last     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            clr_in    = clr_ff + GridBits'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               if (head_cmd.func == vsnl_pkg::FUNC_QUERY) begin
                  pop           = 1'b1;
                  cmd_in        = head_cmd;
                  dir_in        = vsnl_pkg::DIR_NEG_X;
                  chk_valid_in  = 1'b0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_QUERY;
               end else if (can_push) begin
                  pop     = 1'b1;
                  push_en = 1'b1;
                  if (count_ff >= MaxCount) begin
                     push_cap = 1'b1;
                  end else begin
                     count_in    = count_ff + IB'(1);
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = {COORD_BITS'(head_cmd.coord_z),
                                    COORD_BITS'(head_cmd.coord_y),
                                    COORD_BITS'(head_cmd.coord_x)};
                     ram_wr_data = count_ff + IB'(1);
                     push_idx    = count_ff + IB'(1);
                     push_found  = 1'b1;
                  end
               end
            end
         end
         ST_QUERY: begin
            if (!stall) begin
               ram_rd_en    = issuing;
               chk_valid_in = issuing;
               if (issuing) begin
                  chk_dir_in    = dir_ff;
                  chk_inside_in = cmd_ff.in_grid[dir_ff];
                  dir_in        = dir_ff + DB'(1);
               end else begin
                  state_in = ST_FINISH;
               end
               if (hit) begin
                  if (pend_valid_ff) begin
                     push_en    = 1'b1;
                     push_idx   = pend_idx_ff;
                     push_dir   = pend_dir_ff;
                     push_found = 1'b1;
                     push_last  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = ram_rd_data;
                  pend_dir_in   = chk_dir_ff;
               end
            end
         end
         ST_FINISH: begin
            if (can_push) begin
               push_en       = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
               if (pend_valid_ff) begin
                  push_idx   = pend_idx_ff;
                  push_dir   = pend_dir_ff;
                  push_found = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_found_in = rsp_found_ff;
      rsp_cap_in   = rsp_cap_ff;
      rsp_last_in  = rsp_last_ff;
      if (push_en) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = push_idx;
         rsp_dir_in   = push_dir;
         rsp_found_in = push_found;
         rsp_cap_in   = push_cap;
         rsp_last_in  = push_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         dir_ff        <= vsnl_pkg::DIR_DONE;
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         dir_ff        <= dir_in;
         chk_valid_ff  <= chk_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      chk_dir_ff    <= chk_dir_in;
      chk_inside_ff <= chk_inside_in;
      pend_idx_ff   <= pend_idx_in;
      pend_dir_ff   <= pend_dir_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_cap_ff    <= rsp_cap_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.voxel_index    = rsp_idx_ff;
   assign rsp_chan.direction      = rsp_dir_ff;
   assign rsp_chan.found          = rsp_found_ff;
   assign rsp_chan.capacity_error = rsp_cap_ff;
   assign rsp_chan.last           = rsp_last_ff;

endmodule

### hdl/voxel_six_neighbor_lookup.sv
// Voxel occupancy grid with six-connected neighbor lookup.
// Usage: req_chan carries func (insert or query) and x/y/z coordinates;
// rsp_chan returns voxel_index, direction, found, capacity_error and last.
// An insert gives one response; a query gives one response per occupied
// neighbor in the order -x, +x, -y, +y, -z, +z, or a single not-found one.
// After reset the grid RAM, all 2^(3*COORD_BITS) entries (262144 at the
// default size), is swept to zero one entry per cycle; req_chan.ready stays
// low during the sweep. Then a two-entry command queue decouples intake
// from execution: the front takes a transaction per cycle while the queue
// has room. An insert takes one RAM write in the back section, so inserts
// sustain one per cycle while rsp_chan takes responses. A query steps
// through fetching the command, six grid RAM reads, a check of the last
// read and settling the final response. Responses leave through an output
// register, behind the command queue; while rsp_chan is stalled the back
// section holds once it has a response to push, and the queue keeps
// filling until full.
// Depends on vsnl_pkg, vsnl_if, vsnl_front, vsnl_queue, vsnl_back.
`include "voxel_six_neighbor_lookup_defines.svh"

module voxel_six_neighbor_lookup #(
   parameter int COORD_BITS = vsnl_pkg::COORD_BITS_DEFAULT,
   parameter int MAX_VOXELS = vsnl_pkg::MAX_VOXELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   vsnl_req_if.sink   req_chan,
   vsnl_rsp_if.source rsp_chan
);

   vsnl_pkg::back_status_type status;
   vsnl_pkg::cmd_type         push_cmd, head_cmd;
   logic                      push, queue_full, pop, head_valid;

   vsnl_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .reset      (reset),
      .req_chan   (req_chan),
      .status     (status),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   vsnl_queue #(
      .DEPTH (vsnl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   vsnl_back #(
      .COORD_BITS (COORD_BITS),
      .MAX_VOXELS (MAX_VOXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .status     (status),
      .rsp_chan   (rsp_chan)
   );

   // checks
   `VSNL_ASSERT_IMPLY(a_no_intake_while_clearing, clock, reset, req_chan.ready, !status.clearing)
   `VSNL_ASSERT_IMPLY(a_no_rsp_while_clearing, clock, reset, rsp_chan.valid, !status.clearing)
   `VSNL_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, pop && !head_valid)
   `VSNL_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && queue_full)

endmodule

### bench/tb_voxel_six_neighbor_lookup.sv
// Self-checking bench for voxel_six_neighbor_lookup: inserts and neighbor queries
// against a behavioral grid model. Depends on vsnl_pkg, vsnl_if and the block's RTL.
// Runs the default grid size and voxel limit, so the full clear sweep comes first.
module tb_voxel_six_neighbor_lookup;

   // default grid: neighbors clustered in a small cube so queries hit often
   localparam int GRID_BITS    = vsnl_pkg::COORD_BITS_DEFAULT;
   localparam int VOXEL_LIMIT  = vsnl_pkg::MAX_VOXELS_DEFAULT;
   localparam int GRID_CELLS   = 1 << (3 * GRID_BITS);
   localparam int AXIS_MAX     = (1 << GRID_BITS) - 1;
   localparam int RANDOM_ITEMS = 100;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   localparam logic OP_INS = vsnl_pkg::FUNC_INSERT;
   localparam logic OP_QRY = vsnl_pkg::FUNC_QUERY;

   typedef struct packed {
      logic [vsnl_pkg::INDEX_BITS-1:0] index;
      logic [vsnl_pkg::DIR_BITS-1:0]   dir;
      logic                            found;
      logic                            cap_err;
      logic                            last;
   } voxel_rsp_type;

   typedef struct packed {
      logic                            func;
      logic [vsnl_pkg::FIELD_BITS-1:0] x;
      logic [vsnl_pkg::FIELD_BITS-1:0] y;
      logic [vsnl_pkg::FIELD_BITS-1:0] z;
      bit                              typed;
      voxel_rsp_type                   rsp;
   } stim_row_type;

   localparam voxel_rsp_type UNTYPED   = '0;
   localparam voxel_rsp_type NOT_FOUND = '{16'd0, vsnl_pkg::DIR_NEG_X, 1'b0, 1'b0, 1'b1};
   localparam voxel_rsp_type FIRST_INS = '{16'd1, vsnl_pkg::DIR_NEG_X, 1'b1, 1'b0, 1'b1};
   localparam voxel_rsp_type FIRST_PX  = '{16'd1, vsnl_pkg::DIR_POS_X, 1'b1, 1'b0, 1'b1};

   localparam logic [vsnl_pkg::DIR_BITS-1:0] PROBE_ORDER [vsnl_pkg::NUM_DIRS] =
      '{vsnl_pkg::DIR_NEG_X, vsnl_pkg::DIR_POS_X, vsnl_pkg::DIR_NEG_Y,
        vsnl_pkg::DIR_POS_Y, vsnl_pkg::DIR_NEG_Z, vsnl_pkg::DIR_POS_Z};

   // directed rows: empty grid, first insert, full neighborhood, corners
   localparam int DIRECTED_COUNT = 21;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_QRY, 6'd0,  6'd0,  6'd0,  1'b1, NOT_FOUND},
      '{OP_QRY, 6'd63, 6'd63, 6'd63, 1'b1, NOT_FOUND},
      '{OP_INS, 6'd3,  6'd3,  6'd3,  1'b1, FIRST_INS},
      '{OP_QRY, 6'd2,  6'd3,  6'd3,  1'b1, FIRST_PX},
      '{OP_INS, 6'd2,  6'd3,  6'd3,  1'b0, UNTYPED},
      '{OP_INS, 6'd4,  6'd3,  6'd3,  1'b0, UNTYPED},
      '{OP_INS, 6'd3,  6'd2,  6'd3,  1'b0, UNTYPED},
      '{OP_INS, 6'd3,  6'd4,  6'd3,  1'b0, UNTYPED},
      '{OP_INS, 6'd3,  6'd3,  6'd2,  1'b0, UNTYPED},
      '{OP_INS, 6'd3,  6'd3,  6'd4,  1'b0, UNTYPED},
      '{OP_QRY, 6'd3,  6'd3,  6'd3,  1'b0, UNTYPED},
      '{OP_INS, 6'd11, 6'd51, 6'd27, 1'b0, UNTYPED},
      '{OP_QRY, 6'd2,  6'd3,  6'd3,  1'b0, UNTYPED},
      '{OP_QRY, 6'd35, 6'd3,  6'd3,  1'b0, UNTYPED},
      '{OP_INS, 6'd0,  6'd0,  6'd0,  1'b0, UNTYPED},
      '{OP_INS, 6'd63, 6'd63, 6'd63, 1'b0, UNTYPED},
      '{OP_QRY, 6'd1,  6'd0,  6'd0,  1'b0, UNTYPED},
      '{OP_QRY, 6'd0,  6'd0,  6'd0,  1'b0, UNTYPED},
      '{OP_QRY, 6'd63, 6'd62, 6'd63, 1'b0, UNTYPED},
      '{OP_QRY, 6'd62, 6'd63, 6'd63, 1'b0, UNTYPED},
      '{OP_QRY, 6'd63, 6'd63, 6'd63, 1'b0, UNTYPED}
   };

   logic clock;
   logic reset;
   logic hold_off = 1'b0;

   vsnl_req_if req_chan ();
   vsnl_rsp_if rsp_chan ();

   voxel_six_neighbor_lookup #(
      .COORD_BITS(GRID_BITS),
      .MAX_VOXELS(VOXEL_LIMIT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // grid model and bookkeeping
   logic [vsnl_pkg::INDEX_BITS-1:0] grid_model [GRID_CELLS];
   int                              voxels_stored  = 0;
   voxel_rsp_type                   awaited_rsp_q [$];
   int                              mismatch_count = 0;
   int                              accepted_items = 0;
   int                              req_calm       = 0;
   int                              rsp_calm       = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      foreach (grid_model[i]) grid_model[i] = '0;
   end

   // append one expected response at the tail of the queue
   function automatic void await_rsp(voxel_rsp_type r);
      awaited_rsp_q.insert(awaited_rsp_q.size(), r);
   endfunction

   // gap before next transaction, 0..9, with occasional runs of back-to-back traffic
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // mostly clustered in a small cube so queries hit neighbors
   function automatic logic [vsnl_pkg::FIELD_BITS-1:0] rand_coord();
      logic [vsnl_pkg::FIELD_BITS-1:0] c;
      c = vsnl_pkg::FIELD_BITS'($urandom_range(0, (1 << vsnl_pkg::FIELD_BITS) - 1));
      if ($urandom_range(0, 3) != 0)
         c[GRID_BITS-1:0] = GRID_BITS'($urandom_range(2, 5));
      return c;
   endfunction

   function automatic int cell_of(int x, int y, int z);
      return (z << (2 * GRID_BITS)) | (y << GRID_BITS) | x;
   endfunction

   // update grid model for one transaction and queue the responses it causes
   function automatic void predict_lookup(logic func,
                                          logic [vsnl_pkg::FIELD_BITS-1:0] x,
                                          logic [vsnl_pkg::FIELD_BITS-1:0] y,
                                          logic [vsnl_pkg::FIELD_BITS-1:0] z);
      int                              px;
      int                              py;
      int                              pz;
      int                              nx;
      int                              ny;
      int                              nz;
      int                              hits;
      logic [vsnl_pkg::INDEX_BITS-1:0] v;
      px = int'(x) & AXIS_MAX;
      py = int'(y) & AXIS_MAX;
      pz = int'(z) & AXIS_MAX;
      if (func == vsnl_pkg::FUNC_INSERT) begin
         if (voxels_stored >= VOXEL_LIMIT) begin
            await_rsp('{16'd0, vsnl_pkg::DIR_NEG_X, 1'b0, 1'b1, 1'b1});
         end else begin
            voxels_stored++;
            grid_model[cell_of(px, py, pz)] = vsnl_pkg::INDEX_BITS'(voxels_stored);
            await_rsp('{vsnl_pkg::INDEX_BITS'(voxels_stored), vsnl_pkg::DIR_NEG_X,
                        1'b1, 1'b0, 1'b1});
         end
         return;
      end
      hits = 0;
      for (int d = 0; d < vsnl_pkg::NUM_DIRS; d++) begin
         nx = px;
         ny = py;
         nz = pz;
         case (PROBE_ORDER[d])
            vsnl_pkg::DIR_NEG_X: nx = px - 1;
            vsnl_pkg::DIR_POS_X: nx = px + 1;
            vsnl_pkg::DIR_NEG_Y: ny = py - 1;
            vsnl_pkg::DIR_POS_Y: ny = py + 1;
            vsnl_pkg::DIR_NEG_Z: nz = pz - 1;
            default:             nz = pz + 1;
         endcase
         // probes off the grid edge are absent neighbors
         if (nx < 0 || nx > AXIS_MAX || ny < 0 || ny > AXIS_MAX ||
             nz < 0 || nz > AXIS_MAX)
            continue;
         v = grid_model[cell_of(nx, ny, nz)];
         if (v != '0) begin
            await_rsp('{v, PROBE_ORDER[d], 1'b1, 1'b0, 1'b0});
            hits++;
         end
      end
      if (hits == 0)
         await_rsp(NOT_FOUND);
      else
         awaited_rsp_q[$].last = 1'b1;
   endfunction

   function automatic string rsp_text(voxel_rsp_type r);
      return $sformatf("idx=%0d dir=%0d found=%0b cap=%0b last=%0b",
                       r.index, r.dir, r.found, r.cap_err, r.last);
   endfunction

   task automatic note_mismatch(string what, voxel_rsp_type exp_rsp,
                                voxel_rsp_type got_rsp);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s: exp %s, got %s", what, rsp_text(exp_rsp), rsp_text(got_rsp));
   endtask

   // offer one request transaction; predict its responses once it is taken
   task automatic offer_request(input logic func,
                                input logic [vsnl_pkg::FIELD_BITS-1:0] x,
                                input logic [vsnl_pkg::FIELD_BITS-1:0] y,
                                input logic [vsnl_pkg::FIELD_BITS-1:0] z,
                                input bit typed, input voxel_rsp_type typed_rsp);
      int gap;
      int depth;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= func;
      req_chan.coord_x <= x;
      req_chan.coord_y <= y;
      req_chan.coord_z <= z;
      do @(posedge clock); while (!req_chan.ready);
      depth = awaited_rsp_q.size();
      predict_lookup(func, x, y, z);
      // a typed row replaces the prediction with its hand-written response
      if (typed) begin
         while (awaited_rsp_q.size() > depth) void'(awaited_rsp_q.pop_back());
         await_rsp(typed_rsp);
      end
      accepted_items++;
   endtask

   // response side: random stalls, check each transaction against the oldest expectation
   initial begin : rsp_side
      int            gap;
      voxel_rsp_type got_rsp;
      voxel_rsp_type exp_rsp;
      gap = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_rsp = '{rsp_chan.voxel_index, rsp_chan.direction, rsp_chan.found,
                        rsp_chan.capacity_error, rsp_chan.last};
            if (awaited_rsp_q.size() == 0) begin
               note_mismatch("unexpected response", UNTYPED, got_rsp);
            end else begin
               exp_rsp = awaited_rsp_q.pop_front();
               if (got_rsp.index !== exp_rsp.index || got_rsp.dir !== exp_rsp.dir ||
                   got_rsp.found !== exp_rsp.found ||
                   got_rsp.cap_err !== exp_rsp.cap_err ||
                   got_rsp.last !== exp_rsp.last)
                  note_mismatch("response mismatch", exp_rsp, got_rsp);
            end
            gap = draw_gap(rsp_calm);
         end else if (gap > 0) begin
            gap--;
         end
         rsp_chan.ready <= (gap == 0) && !hold_off;
      end
   end

   // long receiver stall partway through the random traffic to back up the block
   initial begin
      wait (accepted_items >= DIRECTED_COUNT + 30);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // stimulus: reset, directed table, then random traffic
   initial begin : req_side
      logic func;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.func    <= vsnl_pkg::FUNC_INSERT;
      req_chan.coord_x <= '0;
      req_chan.coord_y <= '0;
      req_chan.coord_z <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         offer_request(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y,
                       DIRECTED_ROWS[i].z, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         func = ($urandom_range(0, 9) < 6) ? vsnl_pkg::FUNC_INSERT : vsnl_pkg::FUNC_QUERY;
         offer_request(func, rand_coord(), rand_coord(), rand_coord(), 1'b0, UNTYPED);
      end
      req_chan.valid <= 1'b0;

      // drain, then a few more cycles to catch stray responses
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_rsp_q.size() != 0)
         note_mismatch("missing response", awaited_rsp_q[0], UNTYPED);

      if (mismatch_count == 0)
         $display("tb_voxel_six_neighbor_lookup: clean");
      else
         $display("tb_voxel_six_neighbor_lookup: errors");
      $finish;
   end

   // watchdog: clear sweep plus traffic under the longest stalls, with wide margin
   initial begin
      #2000000;
      $display("tb_voxel_six_neighbor_lookup: errors");
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/vsnl_pkg.sv
hdl/vsnl_if.sv
hdl/vsnl_ram.sv
hdl/vsnl_front.sv
hdl/vsnl_queue.sv
hdl/vsnl_back.sv
hdl/voxel_six_neighbor_lookup.sv
bench/tb_voxel_six_neighbor_lookup.sv
